// ===== hdl/tlvc_pkg.sv =====
// Package for the TLV chunk id counter: field widths, register indexes,
// parse phase type. No dependencies.
package tlvc_pkg;

   localparam int DataW   = 8;
   localparam int RegionW = 31;
   localparam int CountW  = 30;
   localparam int AccW    = 32;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 31;

   localparam logic [CsrIdxW-1:0] CSR_REGION_LENGTH = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_TARGET_ID     = 1'd1;

   localparam logic [CountW-1:0] COUNT_MAX    = {CountW{1'b1}};
   localparam logic [DataW-1:0]  TARGET_RESET = {DataW{1'b1}};

   typedef enum logic [2:0] {
      PH_ID,
      PH_LEN0,
      PH_LENX,
      PH_PAYLOAD,
      PH_STOP
   } phase_type;

endpackage

// ===== hdl/tlvc_req_if.sv =====
// Input byte channel of the TLV chunk id counter.
// Depends on tlvc_pkg.
interface tlvc_req_if;
   logic                       valid;
   logic                       ready;
   logic [tlvc_pkg::DataW-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hdl/tlvc_rsp_if.sv =====
// Result channel of the TLV chunk id counter.
// Depends on tlvc_pkg.
interface tlvc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tlvc_pkg::CountW-1:0] chunk_count;

   modport source (output valid, output chunk_count, input ready);
   modport sink   (input valid, input chunk_count, output ready);
endinterface

// ===== hdl/tlvc_csr_if.sv =====
// Register write channel of the TLV chunk id counter.
// Depends on tlvc_pkg.
interface tlvc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tlvc_pkg::CsrIdxW-1:0]  index;
   logic [tlvc_pkg::CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tlv_chunk_id_counter.sv =====
// Top level of the TLV chunk id counter: parses a region of TLV chunks one
// byte per transaction and reports the matching chunk count at region end.
// Depends on tlvc_pkg, tlvc_req_if, tlvc_rsp_if, tlvc_csr_if.
//
//   port      dir  payload                      transaction
//   req_bus   in   data_byte[7:0]               one region byte
//   rsp_bus   out  chunk_count[29:0]            count at last region byte
//   csr_bus   in   index[0], data[30:0]         register write
//
// One byte per cycle while req_bus.ready is high; each byte is parsed in the cycle it is accepted and the
// count lands in the output register on the next edge.
// req_bus.ready stays high unless a count waits in the output register and
// rsp_bus.ready is low. csr_bus.ready is always high.
// Synchronous reset clears the parse state and the registers to their
// defaults (region_length 0, target_id 255).
module tlv_chunk_id_counter (
   input logic clock,
   input logic reset,
   tlvc_req_if.sink   req_bus,
   tlvc_rsp_if.source rsp_bus,
   tlvc_csr_if.sink   csr_bus
);
   import tlvc_pkg::*;

   logic [RegionW-1:0] region_len_ff;
   logic [DataW-1:0]   target_ff;

   phase_type          phase_ff, phase_in;
   logic [RegionW-1:0] pos_ff;
   logic [AccW-1:0]    acc_ff, acc_in;
   logic [1:0]         extra_ff, extra_in;
   logic [RegionW-1:0] rem_ff, rem_in;
   logic               match_ff, match_in;
   logic [CountW-1:0]  total_ff, total_in;

   logic               rsp_valid_ff;
   logic [CountW-1:0]  rsp_count_ff;

   logic               req_accept;
   logic [DataW-1:0]   byte_val;
   logic [RegionW:0]   hdr_end;
   logic [RegionW:0]   id_need;
   logic               id_fits;
   logic [AccW-1:0]    acc_merge;
   logic [RegionW-1:0] hdr_len;
   logic               hdr_done;
   logic               hdr_fits;
   logic               region_end;
   phase_type          hdr_next;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign byte_val      = req_bus.data_byte;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.chunk_count = rsp_count_ff;

   assign hdr_end    = {1'b0, pos_ff} + (RegionW+1)'(1);
   assign id_need    = {1'b0, pos_ff} + (RegionW+1)'(2);
   assign id_fits    = id_need <= {1'b0, region_len_ff};
   assign region_end = hdr_end >= {1'b0, region_len_ff};

   // merge the next long-length byte into its little-endian slot
   always_comb begin
      case (extra_ff)
         2'd3:    acc_merge = acc_ff | {16'd0, byte_val, 8'd0};
         2'd2:    acc_merge = acc_ff | {8'd0, byte_val, 16'd0};
         2'd1:    acc_merge = acc_ff | {byte_val, 24'd0};
         default: acc_merge = acc_ff;
      endcase
   end

   always_comb begin
      if (phase_ff == PH_LEN0) begin
         hdr_len = {{(RegionW-DataW+1){1'b0}}, byte_val[DataW-1:1]};
      end else begin
         hdr_len = acc_merge[AccW-1:1];
      end
   end

   assign hdr_done = (phase_ff == PH_LEN0 && !byte_val[0]) ||
                     (phase_ff == PH_LENX && extra_ff == 2'd1);
   assign hdr_fits = ({1'b0, hdr_end} + {2'b0, hdr_len}) <= {2'b0, region_len_ff};

   always_comb begin
      if (!hdr_fits) begin
         hdr_next = PH_STOP;
      end else if (hdr_len == '0) begin
         hdr_next = PH_ID;
      end else begin
         hdr_next = PH_PAYLOAD;
      end
   end

   // next parse phase
   always_comb begin
      case (phase_ff)
         PH_ID:      phase_in = id_fits ? PH_LEN0 : PH_STOP;
         PH_LEN0:    phase_in = byte_val[0] ? PH_LENX : hdr_next;
         PH_LENX:    phase_in = (extra_ff == 2'd1) ? hdr_next : PH_LENX;
         PH_PAYLOAD: phase_in = (rem_ff == RegionW'(1)) ? PH_ID : PH_PAYLOAD;
         default:    phase_in = PH_STOP;
      endcase
   end

   // datapath updates per phase
   always_comb begin
      acc_in   = acc_ff;
      extra_in = extra_ff;
      rem_in   = rem_ff;
      match_in = match_ff;
      total_in = total_ff;
      case (phase_ff)
         PH_ID: begin
            if (id_fits) begin
               match_in = (byte_val == target_ff);
            end
         end
         PH_LEN0: begin
            acc_in = {{(AccW-DataW){1'b0}}, byte_val};
            if (byte_val[0]) begin
               extra_in = 2'd3;
            end
         end
         PH_LENX: begin
            acc_in   = acc_merge;
            extra_in = extra_ff - 2'd1;
         end
         PH_PAYLOAD: begin
            rem_in = rem_ff - RegionW'(1);
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
      if (hdr_done && hdr_fits) begin
         rem_in = hdr_len;
         if (match_ff && total_ff != COUNT_MAX) begin
            total_in = total_ff + CountW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID;
         pos_ff   <= '0;
         acc_ff   <= '0;
         extra_ff <= '0;
         rem_ff   <= '0;
         match_ff <= 1'b0;
         total_ff <= '0;
      end else if (req_accept) begin
         if (region_end) begin
            phase_ff <= PH_ID;
            pos_ff   <= '0;
            acc_ff   <= '0;
            extra_ff <= '0;
            rem_ff   <= '0;
            match_ff <= 1'b0;
            total_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= hdr_end[RegionW-1:0];
            acc_ff   <= acc_in;
            extra_ff <= extra_in;
            rem_ff   <= rem_in;
            match_ff <= match_in;
            total_ff <= total_in;
         end
      end
   end

   // output register: load the count at region end, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && region_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && region_end) begin
         rsp_count_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_len_ff <= '0;
         target_ff     <= TARGET_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_REGION_LENGTH: region_len_ff <= csr_bus.data[RegionW-1:0];
            CSR_TARGET_ID:     target_ff     <= csr_bus.data[DataW-1:0];
            default:           target_ff     <= target_ff;
         endcase
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Testbench for tlv_chunk_id_counter: directed and random byte regions with random
// idling, each result checked against a parse predictor kept inside the bench.
// Depends on tlvc_pkg, tlvc_req_if, tlvc_rsp_if, tlvc_csr_if and the RTL top level.
module testbench;
   import tlvc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlvc_req_if req_bus ();
   tlvc_rsp_if rsp_bus ();
   tlvc_csr_if csr_bus ();

   tlv_chunk_id_counter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies and parse state of the predictor
   logic [RegionW-1:0] cfg_region_len;
   logic [DataW-1:0]   cfg_target;
   phase_type          prd_phase;
   logic [RegionW-1:0] prd_pos;
   logic [AccW-1:0]    prd_len_acc;
   logic [1:0]         prd_extra;
   logic [RegionW-1:0] prd_payload_left;
   logic               prd_id_hit;
   logic [CountW-1:0]  prd_total;

   logic [CountW-1:0] expected_counts[$];
   int fail_count = 0;

   int req_idle_pct    = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_cycles = 0;

   task automatic clear_region_state();
      prd_phase        = PH_ID;
      prd_pos          = '0;
      prd_len_acc      = '0;
      prd_extra        = '0;
      prd_payload_left = '0;
      prd_id_hit       = 1'b0;
      prd_total        = '0;
   endtask

   // header ends at pos: stop if the chunk overruns the region, else count and skip
   task automatic finish_header(input logic [RegionW-1:0] pos, input logic [AccW-1:0] len);
      logic [33:0] hdr_end;
      hdr_end = 34'(pos) + 34'd1;
      if (hdr_end + 34'(len) > 34'(cfg_region_len)) begin
         prd_phase = PH_STOP;
      end else begin
         if (prd_id_hit && prd_total != COUNT_MAX)
            prd_total = prd_total + CountW'(1);
         if (len == '0) begin
            prd_phase = PH_ID;
         end else begin
            prd_payload_left = len[RegionW-1:0];
            prd_phase        = PH_PAYLOAD;
         end
      end
   endtask

   task automatic predict_byte(input logic [DataW-1:0] b);
      logic [RegionW-1:0] pos;
      pos = prd_pos;
      case (prd_phase)
         PH_ID: begin
            if (33'(pos) + 33'd2 > 33'(cfg_region_len)) begin
               prd_phase = PH_STOP;
            end else begin
               prd_id_hit = (b == cfg_target);
               prd_phase  = PH_LEN0;
            end
         end
         PH_LEN0: begin
            prd_len_acc = AccW'(b);
            if (b[0]) begin
               prd_extra = 2'd3;
               prd_phase = PH_LENX;
            end else begin
               finish_header(pos, AccW'(b >> 1));
            end
         end
         PH_LENX: begin
            prd_len_acc = prd_len_acc | (AccW'(b) << (8 * (4 - int'(prd_extra))));
            prd_extra   = prd_extra - 2'd1;
            if (prd_extra == 2'd0)
               finish_header(pos, prd_len_acc >> 1);
         end
         PH_PAYLOAD: begin
            prd_payload_left = prd_payload_left - RegionW'(1);
            if (prd_payload_left == '0)
               prd_phase = PH_ID;
         end
         default: begin
            prd_phase = PH_STOP;
         end
      endcase
      if (33'(pos) + 33'd1 >= 33'(cfg_region_len)) begin
         expected_counts.push_back(prd_total);
         clear_region_state();
      end else begin
         prd_pos = pos + RegionW'(1);
      end
   endtask

   // entered and left just after a falling edge; leaves valid high for the next byte
   task automatic send_byte(input logic [DataW-1:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_byte(b);
      @(negedge clock);
   endtask

   task automatic wait_for_counts();
      req_bus.valid <= 1'b0;
      while (expected_counts.size() != 0)
         @(negedge clock);
      // bytes that end no region may still be in flight
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] value);
      wait_for_counts();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      if (idx == CSR_REGION_LENGTH)
         cfg_region_len = value;
      else if (idx == CSR_TARGET_ID)
         cfg_target = value[DataW-1:0];
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   always @(posedge clock) begin : check_counts
      logic [CountW-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: chunk_count expected none, actual %0d", $time,
                     rsp_bus.chunk_count);
            fail_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_bus.chunk_count !== want) begin
               $display("%0t: chunk_count expected %0d, actual %0d", $time, want,
                        rsp_bus.chunk_count);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off counted here
   initial begin : drive_rsp_ready
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            hold_left       = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // region length 0 after reset: every byte is a region of its own
   task automatic test_empty_region();
      send_byte(8'hFF);
      send_byte(8'h00);
   endtask

   // two short chunks, then an id byte too close to the region end
   task automatic test_short_chunks();
      csr_write(CSR_TARGET_ID, CsrDataW'(TARGET_RESET));
      csr_write(CSR_REGION_LENGTH, 31'd6);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h02);
      send_byte(8'hAA);
      send_byte(8'h07);
   endtask

   // four-byte length, payload, then a zero-length chunk ending exactly at the end
   task automatic test_long_length();
      csr_write(CSR_TARGET_ID, 31'd0);
      csr_write(CSR_REGION_LENGTH, 31'd8);
      send_byte(8'h00);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
   endtask

   // long header cut by the region end, then a payload that overruns it
   task automatic test_cut_and_oversize();
      csr_write(CSR_REGION_LENGTH, 31'd4);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h0A);
      send_byte(8'h01);
      send_byte(8'h02);
   endtask

   // maximum region, then shrink it below the current position mid-region
   task automatic test_region_cut_short();
      csr_write(CSR_REGION_LENGTH, {RegionW{1'b1}});
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      csr_write(CSR_REGION_LENGTH, 31'd2);
      send_byte(8'h00);
   endtask

   task automatic test_random_regions();
      int sent;
      int mode;
      int pick;
      int n;
      int unsigned span;
      int unsigned len;
      logic [AccW-1:0]     word;
      logic [DataW-1:0]    tgt;
      logic [CsrDataW-1:0] value;
      logic [DataW-1:0]    region_bytes[$];
      sent = 0;
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 56; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin req_idle_pct = 31; rsp_stall_pct = 31; end
         endcase
         while (sent < 150 * (mode + 1)) begin
            pick = $urandom_range(99);
            if (pick < 5)       span = 0;
            else if (pick < 10) span = 1;
            else if (pick < 15) span = 2;
            else if (pick < 20) span = 3;
            else if (pick < 24) span = $urandom_range(300, 100);
            else                span = $urandom_range(40, 4);
            csr_write(CSR_REGION_LENGTH, CsrDataW'(span));
            if ($urandom_range(2) == 0) begin
               pick = $urandom_range(99);
               if (pick < 20)      tgt = 8'h00;
               else if (pick < 40) tgt = 8'hFF;
               else                tgt = 8'($urandom);
               // upper data bits are don't-care for the id register
               value = CsrDataW'($urandom);
               value[DataW-1:0] = tgt;
               csr_write(CSR_TARGET_ID, value);
            end
            repeat ($urandom_range(3, 1)) begin
               if (span == 0) begin
                  repeat ($urandom_range(3, 1)) begin
                     send_byte(8'($urandom));
                     sent++;
                  end
               end else begin
                  region_bytes.delete();
                  while (region_bytes.size() < span) begin
                     pick = $urandom_range(99);
                     if (pick < 8) begin
                        region_bytes.push_back(8'($urandom));
                     end else begin
                        region_bytes.push_back(($urandom_range(1) == 0) ? cfg_target
                                                                        : 8'($urandom));
                        pick = $urandom_range(99);
                        if (pick < 70) begin
                           len = $urandom_range(6, 0);
                           region_bytes.push_back(8'(len << 1));
                        end else if (pick < 85) begin
                           len  = $urandom_range(12, 0);
                           word = AccW'((len << 1) | 1);
                           for (n = 0; n < 4; n++)
                              region_bytes.push_back(word[8*n +: 8]);
                        end else if (pick < 93) begin
                           len = $urandom_range(127, 0);
                           region_bytes.push_back(8'(len << 1));
                        end else begin
                           // random long length, nearly always past the region end
                           len  = 0;
                           word = AccW'($urandom) | 32'd1;
                           for (n = 0; n < 4; n++)
                              region_bytes.push_back(word[8*n +: 8]);
                        end
                        repeat (len) region_bytes.push_back(8'($urandom));
                     end
                  end
                  // drop what runs past the region end
                  while (region_bytes.size() > span)
                     void'(region_bytes.pop_back());
                  foreach (region_bytes[k]) begin
                     send_byte(region_bytes[k]);
                     sent++;
                  end
               end
            end
         end
      end
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   // hold the receiver off while bytes keep coming so the input stalls, then drain
   task automatic test_backpressure();
      csr_write(CSR_TARGET_ID, CsrDataW'(8'h5A));
      csr_write(CSR_REGION_LENGTH, 31'd2);
      rsp_hold_cycles = 80;
      repeat (40) send_byte(($urandom_range(1) == 0) ? 8'h5A : 8'($urandom));
      wait_for_counts();
      repeat (20) send_byte(($urandom_range(1) == 0) ? 8'h5A : 8'($urandom));
      wait_for_counts();
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_REGION_LENGTH;
      csr_bus.data      = '0;
      cfg_region_len    = '0;
      cfg_target        = TARGET_RESET;
      clear_region_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_region();
      test_short_chunks();
      test_long_length();
      test_cut_and_oversize();
      test_region_cut_short();
      test_random_regions();
      test_backpressure();
      wait_for_counts();

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tlvc_pkg.sv
hdl/tlvc_req_if.sv
hdl/tlvc_rsp_if.sv
hdl/tlvc_csr_if.sv
hdl/tlv_chunk_id_counter.sv
tb/testbench.sv
